>>> rtl/tet_pkg.sv
// shared widths, request and status codes, and controller/datapath interface types
package tet_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // item field widths
    localparam int REQ_W    = 3;
    localparam int TYPE_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int STAMP_W  = 32;

    // common width for position against entry count compares
    localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD       = 3'd0,
        REQ_READ      = 3'd1,
        REQ_DEL_POS   = 3'd2,
        REQ_DEL_TYPE  = 3'd3,
        REQ_DEL_RANGE = 3'd4,
        REQ_CLEAR     = 3'd5,
        REQ_RESYNC    = 3'd6
    } req_e_t;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic do_add;
        logic do_clear;
        logic set_none;
        logic rd_issue;
        logic rd_take;
        logic find_start;
        logic find_run;
        logic cmp_start;
        logic from_find;
        logic cmp_run;
        logic cmp_commit;
        logic finish;
    } tet_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        req_e_t req;
        logic   pos_ok;
        logic   multi;
        logic   single;
        logic   find_hit;
        logic   find_done;
        logic   cmp_done;
        logic   out_busy;
    } tet_stat_t;

endpackage

>>> rtl/tet_datapath.sv
// entry memory, counters, scan and compaction pointers, and the result register
module tet_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tet_pkg::tet_cmd_t                cmd,
    output tet_pkg::tet_stat_t               stat,
    input  logic [tet_pkg::REQ_W-1:0]        s_req_type,
    input  logic [tet_pkg::TYPE_W-1:0]       s_entry_type,
    input  logic [tet_pkg::ADDR_W-1:0]       s_entry_addr,
    input  logic [tet_pkg::POS_W-1:0]        s_position,
    input  logic [tet_pkg::ADDR_W-1:0]       s_range_low,
    input  logic [tet_pkg::ADDR_W-1:0]       s_range_high,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tet_pkg::STATUS_W-1:0]     m_status,
    output logic [tet_pkg::TYPE_W-1:0]       m_read_type,
    output logic [tet_pkg::ADDR_W-1:0]       m_read_addr,
    output logic [tet_pkg::COUNT_W-1:0]      m_removed_count,
    output logic [tet_pkg::COUNT_W-1:0]      m_entry_count
);
    import tet_pkg::*;

    // entry memory, oldest entry at index 0, newest at held count minus one
    logic [TYPE_W-1:0]   mem_type  [CAPACITY];
    logic [ADDR_W-1:0]   mem_addr  [CAPACITY];
    logic [STAMP_W-1:0]  mem_stamp [CAPACITY];
    logic [TYPE_W-1:0]   rd_type_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;

    // latched request
    req_e_t              req_reg;
    logic [TYPE_W-1:0]   etype_reg;
    logic [ADDR_W-1:0]   eaddr_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [ADDR_W-1:0]   lo_reg;
    logic [ADDR_W-1:0]   hi_reg;

    // table state and scan pointers
    logic [CNT_W-1:0]    held_reg,    held_next;
    logic [STAMP_W-1:0]  stamp_reg,   stamp_next;
    logic [CNT_W-1:0]    rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]    wr_ptr_reg,  wr_ptr_next;
    logic [CNT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]    tgt_reg,     tgt_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;

    // working result
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TYPE_W-1:0]   res_type_reg,   res_type_next;
    logic [ADDR_W-1:0]   res_addr_reg,   res_addr_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TYPE_W-1:0]   out_type_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [COUNT_W-1:0]  out_removed_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // memory port controls
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [TYPE_W-1:0]   mem_wtype;
    logic [ADDR_W-1:0]   mem_waddr_data;
    logic [STAMP_W-1:0]  mem_wstamp;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    // decoded conditions
    logic [WIDE_W-1:0]   pos_w;
    logic [WIDE_W-1:0]   held_w;
    logic [CNT_W-1:0]    pos_cnt;
    logic [IDX_W-1:0]    front_idx;
    logic [CNT_W-1:0]    rd_dec;
    logic                pos_ok;
    logic                full;
    logic                single;
    logic                in_range;
    logic                tgt_mode;
    logic                drop;
    logic                rd_more;
    logic [CNT_W-1:0]    tgt_new;

    // position and range decode
    always_comb begin
        pos_w     = WIDE_W'(pos_reg);
        held_w    = WIDE_W'(held_reg);
        pos_cnt   = CNT_W'(held_w - pos_w);
        front_idx = IDX_W'(held_reg - CNT_W'(1));
        rd_dec    = rd_ptr_reg - CNT_W'(1);
        pos_ok    = (pos_reg != '0) && (pos_w <= held_w);
        full      = (held_reg >= CNT_W'(CAPACITY));
        single    = (lo_reg == hi_reg);
        in_range  = (rd_addr_reg >= lo_reg) && (rd_addr_reg <= hi_reg);
        tgt_mode  = (req_reg == REQ_DEL_POS) || ((req_reg == REQ_DEL_RANGE) && single);
        rd_more   = (rd_ptr_reg < held_reg);
        tgt_new   = cmd.from_find ? chk_idx_reg : pos_cnt;
    end

    // which scanned entry is removed
    always_comb begin
        priority if (tgt_mode) begin
            drop = (chk_idx_reg == tgt_reg);
        end else if (req_reg == REQ_DEL_TYPE) begin
            drop = (rd_type_reg == etype_reg);
        end else begin
            drop = in_range;
        end
    end

    // status to the controller
    always_comb begin
        stat.req       = req_reg;
        stat.pos_ok    = pos_ok;
        stat.multi     = (held_reg >= CNT_W'(2));
        stat.single    = single;
        stat.find_hit  = chk_vld_reg && in_range;
        stat.find_done = (rd_ptr_reg == '0) && !chk_vld_reg;
        stat.cmp_done  = !rd_more && !chk_vld_reg;
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    // memory port selection
    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = held_reg[IDX_W-1:0];
        mem_wtype      = etype_reg;
        mem_waddr_data = eaddr_reg;
        mem_wstamp     = stamp_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[IDX_W-1:0];
        if (cmd.do_add && !full) begin
            mem_we = 1'b1;
        end
        if (cmd.cmp_run && chk_vld_reg && !drop) begin
            mem_we         = 1'b1;
            mem_waddr      = wr_ptr_reg[IDX_W-1:0];
            mem_wtype      = rd_type_reg;
            mem_waddr_data = rd_addr_reg;
            mem_wstamp     = rd_stamp_reg;
        end
        if (cmd.rd_issue) begin
            mem_re    = 1'b1;
            mem_raddr = (req_reg == REQ_READ) ? pos_cnt[IDX_W-1:0] : front_idx;
        end
        if (cmd.cmp_run && rd_more) begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_reg[IDX_W-1:0];
        end
        if (cmd.find_run && (rd_ptr_reg != '0)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_dec[IDX_W-1:0];
        end
    end

    // entry memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_type[mem_waddr]  <= mem_wtype;
            mem_addr[mem_waddr]  <= mem_waddr_data;
            mem_stamp[mem_waddr] <= mem_wstamp;
        end
        if (mem_re) begin
            rd_type_reg  <= mem_type[mem_raddr];
            rd_addr_reg  <= mem_addr[mem_raddr];
            rd_stamp_reg <= mem_stamp[mem_raddr];
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= req_e_t'(s_req_type);
            etype_reg <= s_entry_type;
            eaddr_reg <= s_entry_addr;
            pos_reg   <= s_position;
            lo_reg    <= s_range_low;
            hi_reg    <= s_range_high;
        end
    end

    // table state, scan and result next values
    always_comb begin
        held_next       = held_reg;
        stamp_next      = stamp_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        tgt_next        = tgt_reg;
        removed_next    = removed_reg;
        res_status_next = res_status_reg;
        res_type_next   = res_type_reg;
        res_addr_next   = res_addr_reg;

        if (cmd.load) begin
            res_status_next = STATUS_OK;
            res_type_next   = '0;
            res_addr_next   = '0;
            removed_next    = '0;
        end
        // add at the newest end, counter advances even when refused
        if (cmd.do_add) begin
            stamp_next = stamp_reg + STAMP_W'(1);
            if (full) begin
                res_status_next = STATUS_FULL;
            end else begin
                held_next = held_reg + CNT_W'(1);
            end
        end
        if (cmd.do_clear) begin
            removed_next = held_reg;
            held_next    = '0;
            stamp_next   = '0;
        end
        if (cmd.set_none) begin
            res_status_next = STATUS_NONE;
        end
        // read data lands in the cycle after the issue
        if (cmd.rd_take) begin
            if (req_reg == REQ_READ) begin
                res_type_next = rd_type_reg;
                res_addr_next = rd_addr_reg;
            end else begin
                stamp_next = rd_stamp_reg + STAMP_W'(1);
            end
        end
        // search from the newest entry downwards
        if (cmd.find_start) begin
            rd_ptr_next  = held_reg;
            chk_vld_next = 1'b0;
        end
        if (cmd.find_run) begin
            if (rd_ptr_reg != '0) begin
                rd_ptr_next  = rd_dec;
                chk_idx_next = rd_dec;
                chk_vld_next = 1'b1;
            end else begin
                chk_vld_next = 1'b0;
            end
        end
        // compaction pass from the oldest affected entry upwards
        if (cmd.cmp_start) begin
            tgt_next     = tgt_new;
            rd_ptr_next  = tgt_mode ? tgt_new : '0;
            wr_ptr_next  = tgt_mode ? tgt_new : '0;
            chk_vld_next = 1'b0;
            removed_next = '0;
        end
        if (cmd.cmp_run) begin
            if (rd_more) begin
                rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                chk_idx_next = rd_ptr_reg;
                chk_vld_next = 1'b1;
            end else begin
                chk_vld_next = 1'b0;
            end
            if (chk_vld_reg) begin
                if (drop) begin
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                end
            end
        end
        if (cmd.cmp_commit) begin
            held_next       = wr_ptr_reg;
            res_status_next = (removed_reg == '0) ? STATUS_NONE : STATUS_OK;
        end
    end

    // output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            stamp_reg   <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            held_reg    <= held_next;
            stamp_reg   <= stamp_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg     <= rd_ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        chk_idx_reg    <= chk_idx_next;
        tgt_reg        <= tgt_next;
        removed_reg    <= removed_next;
        res_status_reg <= res_status_next;
        res_type_reg   <= res_type_next;
        res_addr_reg   <= res_addr_next;
        if (cmd.finish) begin
            out_status_reg  <= res_status_reg;
            out_type_reg    <= res_type_reg;
            out_addr_reg    <= res_addr_reg;
            out_removed_reg <= COUNT_W'(removed_reg);
            out_count_reg   <= COUNT_W'(held_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_status_reg;
    assign m_read_type     = out_type_reg;
    assign m_read_addr     = out_addr_reg;
    assign m_removed_count = out_removed_reg;
    assign m_entry_count   = out_count_reg;

endmodule

>>> rtl/tet_ctrl.sv
// request sequencer for the timeline entry table
module tet_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tet_pkg::tet_stat_t stat,
    output tet_pkg::tet_cmd_t  cmd
);
    import tet_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_WAIT    = 6'b000100,
        S_FIND    = 6'b001000,
        S_COMPACT = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.req)
                    REQ_ADD: begin
                        cmd.do_add = 1'b1;
                        state_next = S_FINISH;
                    end
                    REQ_READ: begin
                        if (stat.pos_ok) begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_WAIT;
                        end else begin
                            cmd.set_none = 1'b1;
                            state_next   = S_FINISH;
                        end
                    end
                    REQ_DEL_POS: begin
                        if (stat.pos_ok) begin
                            cmd.cmp_start = 1'b1;
                            state_next    = S_COMPACT;
                        end else begin
                            cmd.set_none = 1'b1;
                            state_next   = S_FINISH;
                        end
                    end
                    REQ_DEL_TYPE: begin
                        cmd.cmp_start = 1'b1;
                        state_next    = S_COMPACT;
                    end
                    REQ_DEL_RANGE: begin
                        // a single address removes only the newest match
                        if (stat.single) begin
                            cmd.find_start = 1'b1;
                            state_next     = S_FIND;
                        end else begin
                            cmd.cmp_start = 1'b1;
                            state_next    = S_COMPACT;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.do_clear = 1'b1;
                        state_next   = S_FINISH;
                    end
                    REQ_RESYNC: begin
                        if (stat.multi) begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_WAIT;
                        end else begin
                            state_next = S_FINISH;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WAIT: begin
                cmd.rd_take = 1'b1;
                state_next  = S_FINISH;
            end
            S_FIND: begin
                if (stat.find_hit) begin
                    cmd.cmp_start = 1'b1;
                    cmd.from_find = 1'b1;
                    state_next    = S_COMPACT;
                end else if (stat.find_done) begin
                    cmd.set_none = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.find_run = 1'b1;
                end
            end
            S_COMPACT: begin
                if (stat.cmp_done) begin
                    cmd.cmp_commit = 1'b1;
                    state_next     = S_FINISH;
                end else begin
                    cmd.cmp_run = 1'b1;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/timeline_entry_table.sv
// timeline entry table top level: sequencer plus entry memory datapath
//
// Ordered table of up to CAPACITY notification entries, newest first, held in
// one single-port-read memory with the oldest entry at the lowest address. One
// request item is taken at a time and yields one result item. Delete by
// position, type or range runs a compaction pass over the memory, one entry per
// cycle from the first affected entry. A range delete with equal low and high
// first searches down from the newest entry for the match. A finished result
// sits in an output register; the next item is accepted while it waits, and its
// result is held back until the first one is taken. No clearing pass is needed
// after reset.
module timeline_entry_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tet_pkg::REQ_W-1:0]        s_req_type,
    input  logic [tet_pkg::TYPE_W-1:0]       s_entry_type,
    input  logic [tet_pkg::ADDR_W-1:0]       s_entry_addr,
    input  logic [tet_pkg::POS_W-1:0]        s_position,
    input  logic [tet_pkg::ADDR_W-1:0]       s_range_low,
    input  logic [tet_pkg::ADDR_W-1:0]       s_range_high,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tet_pkg::STATUS_W-1:0]     m_status,
    output logic [tet_pkg::TYPE_W-1:0]       m_read_type,
    output logic [tet_pkg::ADDR_W-1:0]       m_read_addr,
    output logic [tet_pkg::COUNT_W-1:0]      m_removed_count,
    output logic [tet_pkg::COUNT_W-1:0]      m_entry_count
);
    import tet_pkg::*;

    tet_cmd_t  cmd;
    tet_stat_t stat;

    // request sequencer
    tet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entry memory and result path
    tet_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_entry_type    (s_entry_type),
        .s_entry_addr    (s_entry_addr),
        .s_position      (s_position),
        .s_range_low     (s_range_low),
        .s_range_high    (s_range_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_type     (m_read_type),
        .m_read_addr     (m_read_addr),
        .m_removed_count (m_removed_count),
        .m_entry_count   (m_entry_count)
    );

endmodule
